// ===== src/kwa_pkg.sv =====
package kwa_pkg;

   localparam int KEY_BITS         = 10;
   localparam int TOTAL_BITS       = 24;

   // fixed widths of the request and response fields
   localparam int KEY_FIELD_BITS   = 10;
   localparam int WEIGHT_BITS      = 10;
   localparam int TOTAL_FIELD_BITS = 24;

   // presence map: rows of columns, one occupancy flag per row
   localparam int COL_BITS   = KEY_BITS / 2;
   localparam int ROW_BITS   = KEY_BITS - COL_BITS;
   localparam int ROWS       = 1 << ROW_BITS;
   localparam int COLS       = 1 << COL_BITS;
   localparam int TABLE_SIZE = 1 << KEY_BITS;
   localparam int COUNT_BITS = KEY_BITS + 1;
   localparam int SUM_BITS   = ((TOTAL_BITS > WEIGHT_BITS) ? TOTAL_BITS : WEIGHT_BITS) + 1;

   // request queue between front and back
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = 1;
   localparam int QCNT_BITS = 2;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_POP = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [KEY_BITS-1:0]    key;
      logic [WEIGHT_BITS-1:0] weight;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic rows_zero;
   } status_type;

   function automatic logic [KEY_BITS-1:0] key_from_field(input logic [KEY_FIELD_BITS-1:0] f);
      logic [KEY_BITS+KEY_FIELD_BITS-1:0] t;
      t = {{KEY_BITS{1'b0}}, f};
      return t[KEY_BITS-1:0];
   endfunction

   function automatic logic [KEY_FIELD_BITS-1:0] key_to_field(input logic [KEY_BITS-1:0] k);
      logic [KEY_BITS+KEY_FIELD_BITS-1:0] t;
      t = {{KEY_FIELD_BITS{1'b0}}, k};
      return t[KEY_FIELD_BITS-1:0];
   endfunction

   function automatic logic [TOTAL_FIELD_BITS-1:0] total_to_field(
      input logic [TOTAL_BITS-1:0] v);
      logic [TOTAL_BITS+TOTAL_FIELD_BITS-1:0] t;
      t = {{TOTAL_FIELD_BITS{1'b0}}, v};
      return t[TOTAL_FIELD_BITS-1:0];
   endfunction

   function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
                                                     input logic [WEIGHT_BITS-1:0] w);
      logic [SUM_BITS-1:0] s;
      logic [SUM_BITS-1:0] lim;
      lim = SUM_BITS'({TOTAL_BITS{1'b1}});
      s   = SUM_BITS'(a) + SUM_BITS'(w);
      if (s > lim) begin
         s = lim;
      end
      return s[TOTAL_BITS-1:0];
   endfunction

   // lowest set bit wins
   function automatic logic [ROW_BITS-1:0] first_row(input logic [ROWS-1:0] v);
      logic [ROW_BITS-1:0] idx;
      idx = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = ROW_BITS'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [COL_BITS-1:0] first_col(input logic [COLS-1:0] v);
      logic [COL_BITS-1:0] idx;
      idx = '0;
      for (int i = COLS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = COL_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== src/key_weight_accumulate_sorted.sv =====
// A request is written into the queue before the back end can take it; an add reads both
// RAMs as it is taken and writes its total in ST_ADD, a pop passes ST_POP_ROW and ST_POP_TOT
// before its registered response is valid, and a pop on an empty table registers its response
// as it leaves the queue. The back end takes no new command until it is back in ST_IDLE, due
// to the read-modify-write of the total and presence-row RAMs (one read, one write port each).
// Reset (synchronous, active high) clears entry count, row-occupancy flags, queue and
// response slot; RAM contents are not swept, stale rows read as empty.
module key_weight_accumulate_sorted (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [kwa_pkg::KEY_FIELD_BITS-1:0]   req_key,
   input  logic [kwa_pkg::WEIGHT_BITS-1:0]      req_weight,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [kwa_pkg::KEY_FIELD_BITS-1:0]   rsp_out_key,
   output logic [kwa_pkg::TOTAL_FIELD_BITS-1:0] rsp_out_total,
   output logic                                 rsp_found,
   output logic                                 rsp_last
);

   logic                cmd_valid;
   kwa_pkg::cmd_type    cmd;
   logic                cmd_take;
   kwa_pkg::status_type status;

   kwa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_key    (req_key),
      .req_weight (req_weight),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take)
   );

   kwa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_total (rsp_out_total),
      .rsp_found     (rsp_found),
      .rsp_last      (rsp_last),
      .status        (status)
   );

   // entry count and row-occupancy flags must agree on an empty table
   a_count_matches_rows: assert property (@(posedge clock) disable iff (reset)
      status.count_zero == status.rows_zero)
      else $error("entry count and row flags disagree");

   // a miss carries zero payload and marks the table drained
   a_miss_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_out_key == '0 && rsp_out_total == '0)
      else $error("empty pop response malformed");

   // the table is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> status.count_zero && status.rows_zero && !rsp_valid)
      else $error("table not empty after reset");

   // a taken command leaves the queue only when it held one
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from empty queue");

endmodule

// ===== src/kwa_ram.sv =====
module kwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kwa_front.sv =====
module kwa_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [kwa_pkg::KEY_FIELD_BITS-1:0]   req_key,
   input  logic [kwa_pkg::WEIGHT_BITS-1:0]      req_weight,
   output logic                                 cmd_valid,
   output kwa_pkg::cmd_type                     cmd,
   input  logic                                 cmd_take
);

   kwa_pkg::cmd_type               queue_ff [kwa_pkg::QDEPTH];
   logic [kwa_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [kwa_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [kwa_pkg::QCNT_BITS-1:0]  level_ff, level_in;
   kwa_pkg::cmd_type               new_cmd;
   logic                           push;
   logic                           pull;

   assign req_ready = level_ff != kwa_pkg::QCNT_BITS'(kwa_pkg::QDEPTH);
   assign cmd_valid = level_ff != '0;
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pull      = cmd_take && cmd_valid;

   // classify: decode op, fold key into table index
   always_comb begin
      new_cmd.op     = req_op ? kwa_pkg::OP_POP : kwa_pkg::OP_ADD;
      new_cmd.key    = kwa_pkg::key_from_field(req_key);
      new_cmd.weight = req_weight;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == kwa_pkg::QPTR_BITS'(kwa_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + kwa_pkg::QPTR_BITS'(1);
      end
      if (pull) begin
         rd_ptr_in = (rd_ptr_ff == kwa_pkg::QPTR_BITS'(kwa_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + kwa_pkg::QPTR_BITS'(1);
      end
      if (push && !pull) begin
         level_in = level_ff + kwa_pkg::QCNT_BITS'(1);
      end else if (pull && !push) begin
         level_in = level_ff - kwa_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== src/kwa_back.sv =====
module kwa_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   cmd_valid,
   input  kwa_pkg::cmd_type                       cmd,
   output logic                                   cmd_take,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [kwa_pkg::KEY_FIELD_BITS-1:0]     rsp_out_key,
   output logic [kwa_pkg::TOTAL_FIELD_BITS-1:0]   rsp_out_total,
   output logic                                   rsp_found,
   output logic                                   rsp_last,
   output kwa_pkg::status_type                    status
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ADD     = 4'b0010,
      ST_POP_ROW = 4'b0100,
      ST_POP_TOT = 4'b1000
   } state_type;

   state_type                            state_ff, state_in;
   logic [kwa_pkg::ROWS-1:0]             rows_ff, rows_in;
   logic [kwa_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   logic [kwa_pkg::KEY_BITS-1:0]         key_ff, key_in;
   logic [kwa_pkg::WEIGHT_BITS-1:0]      weight_ff, weight_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [kwa_pkg::KEY_BITS-1:0]         rsp_key_ff, rsp_key_in;
   logic [kwa_pkg::TOTAL_BITS-1:0]       rsp_total_ff, rsp_total_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                                 pres_wr_en, pres_rd_en;
   logic [kwa_pkg::ROW_BITS-1:0]         pres_wr_addr, pres_rd_addr;
   logic [kwa_pkg::COLS-1:0]             pres_wr_data, pres_rd_data;
   logic                                 tot_wr_en, tot_rd_en;
   logic [kwa_pkg::KEY_BITS-1:0]         tot_wr_addr, tot_rd_addr;
   logic [kwa_pkg::TOTAL_BITS-1:0]       tot_wr_data, tot_rd_data;

   logic [kwa_pkg::ROW_BITS-1:0]         cur_row;
   logic [kwa_pkg::COL_BITS-1:0]         cur_col;
   logic [kwa_pkg::ROW_BITS-1:0]         scan_row;
   logic [kwa_pkg::COL_BITS-1:0]         scan_col;
   logic [kwa_pkg::COLS-1:0]             row_bits;
   logic [kwa_pkg::COLS-1:0]             row_left;
   logic                                 present;
   logic                                 rsp_free;

   assign cur_row  = key_ff[kwa_pkg::KEY_BITS-1:kwa_pkg::COL_BITS];
   assign cur_col  = key_ff[kwa_pkg::COL_BITS-1:0];
   assign scan_row = kwa_pkg::first_row(rows_ff);
   // a row whose occupancy flag is clear reads as empty, whatever the RAM holds
   assign row_bits = rows_ff[cur_row] ? pres_rd_data : '0;
   assign scan_col = kwa_pkg::first_col(row_bits);
   assign row_left = row_bits & ~(kwa_pkg::COLS'(1) << scan_col);
   assign present  = row_bits[cur_col];
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   kwa_ram #(
      .WIDTH (kwa_pkg::COLS),
      .DEPTH (kwa_pkg::ROWS)
   ) u_pres_ram (
      .clock   (clock),
      .wr_en   (pres_wr_en),
      .wr_addr (pres_wr_addr),
      .wr_data (pres_wr_data),
      .rd_en   (pres_rd_en),
      .rd_addr (pres_rd_addr),
      .rd_data (pres_rd_data)
   );

   kwa_ram #(
      .WIDTH (kwa_pkg::TOTAL_BITS),
      .DEPTH (kwa_pkg::TABLE_SIZE)
   ) u_total_ram (
      .clock   (clock),
      .wr_en   (tot_wr_en),
      .wr_addr (tot_wr_addr),
      .wr_data (tot_wr_data),
      .rd_en   (tot_rd_en),
      .rd_addr (tot_rd_addr),
      .rd_data (tot_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      weight_in    = weight_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_key_in   = rsp_key_ff;
      rsp_total_in = rsp_total_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_take     = 1'b0;
      pres_wr_en   = 1'b0;
      pres_wr_addr = cur_row;
      pres_wr_data = row_left;
      pres_rd_en   = 1'b0;
      pres_rd_addr = cmd.key[kwa_pkg::KEY_BITS-1:kwa_pkg::COL_BITS];
      tot_wr_en    = 1'b0;
      tot_wr_addr  = key_ff;
      tot_wr_data  = kwa_pkg::sat_add(present ? tot_rd_data : '0, weight_ff);
      tot_rd_en    = 1'b0;
      tot_rd_addr  = cmd.key;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == kwa_pkg::OP_ADD) begin
                  cmd_take   = 1'b1;
                  key_in     = cmd.key;
                  weight_in  = cmd.weight;
                  pres_rd_en = 1'b1;
                  tot_rd_en  = 1'b1;
                  state_in   = ST_ADD;
               end else if (rsp_free) begin
                  // pops wait for the response slot so the result never stalls the back end
                  cmd_take = 1'b1;
                  if (rows_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_key_in   = '0;
                     rsp_total_in = '0;
                     rsp_found_in = 1'b0;
                     rsp_last_in  = 1'b1;
                  end else begin
                     key_in       = {scan_row, {kwa_pkg::COL_BITS{1'b0}}};
                     pres_rd_en   = 1'b1;
                     pres_rd_addr = scan_row;
                     state_in     = ST_POP_ROW;
                  end
               end
            end
         end
         ST_ADD: begin
            tot_wr_en        = 1'b1;
            pres_wr_en       = 1'b1;
            pres_wr_data     = row_bits | (kwa_pkg::COLS'(1) << cur_col);
            rows_in[cur_row] = 1'b1;
            if (!present) begin
               count_in = count_ff + kwa_pkg::COUNT_BITS'(1);
            end
            state_in = ST_IDLE;
         end
         ST_POP_ROW: begin
            key_in      = {cur_row, scan_col};
            tot_rd_en   = 1'b1;
            tot_rd_addr = {cur_row, scan_col};
            pres_wr_en  = 1'b1;
            if (row_left == '0) begin
               rows_in[cur_row] = 1'b0;
            end
            count_in = count_ff - kwa_pkg::COUNT_BITS'(1);
            state_in = ST_POP_TOT;
         end
         ST_POP_TOT: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = key_ff;
            rsp_total_in = tot_rd_data;
            rsp_found_in = 1'b1;
            rsp_last_in  = count_ff == '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      weight_ff    <= weight_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_total_ff <= rsp_total_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_key       = kwa_pkg::key_to_field(rsp_key_ff);
   assign rsp_out_total     = kwa_pkg::total_to_field(rsp_total_ff);
   assign rsp_found         = rsp_found_ff;
   assign rsp_last          = rsp_last_ff;
   assign status.count_zero = count_ff == '0;
   assign status.rows_zero  = rows_ff == '0;

endmodule
